[sv/tkf_pkg.sv]
// Shared types, constants and fixed-point helpers for the tilt Kalman fusion unit.
package tkf_pkg;

	// shared multiplier operand and product widths
	localparam int MUL_AW = 36;
	localparam int MUL_BW = 33;
	localparam int MUL_PW = MUL_AW + MUL_BW;

	// shared divider widths
	localparam int DIV_NW = 56;
	localparam int DIV_DW = 36;

	// arccos table entry width, Q8.16 degrees in [0,180]
	localparam int ACOS_W = 24;

	localparam logic [24:0] DT_Q32 = 25'd21474836;
	localparam logic signed [22:0] ACC_BIAS_Q8 = 23'sd346030;
	localparam logic signed [32:0] MV_NUM = 33'sd5000;
	localparam logic signed [39:0] MV_OFFSET_Q20 = 40'sd1730150400;
	localparam logic signed [39:0] COS_DEN = 40'sd8220835840;
	// (n + D) * DEPTH * 2^16 / (2 * D) reduces to ((n + D) * DEPTH >> 10) / 245;
	// the /245 is a multiply by floor(2^36 / 245) on the value >> 4, which lands
	// at most two below the quotient, then a remainder check adds back 0..2
	localparam logic [32:0] POS_RECIP = 33'd280487660;
	localparam logic [9:0] POS_STEP = 10'd245;
	localparam logic [9:0] POS_STEP2 = 10'd490;
	localparam longint HALF_TURN_Q16 = 64'sd11796480;
	localparam longint QUARTER_TURN_Q16 = 64'sd5898240;
	localparam logic [DIV_NW-1:0] GAIN_LIMIT = 56'd1073741824;
	localparam logic signed [31:0] ONE_Q24 = 32'sd16777216;
	localparam logic signed [24:0] FUSED_LIM = 25'sd46080;

	localparam longint ATAN_Q16 [0:19] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335, 14668, 7334,
		3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
	};

	// configuration register indexes
	localparam logic [2:0] CFG_GYRO_OFFSET    = 3'd0;
	localparam logic [2:0] CFG_GYRO_SCALE     = 3'd1;
	localparam logic [2:0] CFG_ACCEL_MID      = 3'd2;
	localparam logic [2:0] CFG_ANGLE_NOISE    = 3'd3;
	localparam logic [2:0] CFG_BIAS_NOISE     = 3'd4;
	localparam logic [2:0] CFG_MEASURE_NOISE  = 3'd5;

	typedef enum logic [5:0] {
		ST_IDLE,
		ST_M_RATE, ST_W_RATE,
		ST_M_X, ST_W_X,
		ST_M_POS, ST_W_POS,
		ST_M_REC, ST_W_REC,
		ST_M_BACK, ST_W_BACK,
		ST_RD0, ST_RD1, ST_RD2, ST_W_INT,
		ST_M_ANG, ST_W_ANG,
		ST_M_P00, ST_W_P00,
		ST_M_P01, ST_W_P01,
		ST_M_P11, ST_W_P11,
		ST_GAIN, ST_D_K0, ST_D_K1,
		ST_M_C11, ST_W_C11,
		ST_M_C10, ST_W_C10,
		ST_M_C01, ST_W_C01,
		ST_M_C00, ST_W_C00,
		ST_M_BIAS, ST_W_BIAS,
		ST_M_ANGC, ST_W_ANGC,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// base +/- round_half_up(prod >> sh), saturated to signed 32 bit
	function automatic logic signed [31:0] rnd_acc(input logic signed [31:0] base,
			input logic signed [MUL_PW-1:0] prod, input int sh, input logic sub);
		logic signed [71:0] t;
		logic signed [71:0] s;
		t = 72'(prod) + (72'sd1 <<< (sh - 1));
		t = t >>> sh;
		s = sub ? (72'(base) - t) : (72'(base) + t);
		if (s > 72'sd2147483647)
			return 32'sh7fffffff;
		else if (s < -72'sd2147483648)
			return 32'sh80000000;
		else
			return 32'(s);
	endfunction

	// quotient magnitude to signed gain, limited to +-64.0
	function automatic logic signed [31:0] gain_sat(input logic [DIV_NW-1:0] q,
			input logic neg);
		logic [31:0] m;
		m = (q > GAIN_LIMIT) ? 32'(GAIN_LIMIT) : 32'(q);
		return neg ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

endpackage

[sv/tkf_mul.sv]
// Shared signed multiplier with registered product.
module tkf_mul import tkf_pkg::*; (
	input  logic                     clk,
	input  logic signed [MUL_AW-1:0] a,
	input  logic signed [MUL_BW-1:0] b,
	output logic signed [MUL_PW-1:0] prod
);
	logic signed [MUL_PW-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= MUL_PW'(a) * MUL_PW'(b);
	end

	assign prod = prod_q;
endmodule

[sv/tkf_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module tkf_div import tkf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] dividend,
	input  logic [DIV_DW-1:0] divisor,
	output div_stat_t         stat,
	output logic [DIV_NW-1:0] quotient
);
	localparam int CW = $clog2(DIV_NW);

	logic [DIV_NW-1:0] work_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] dvs_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   trial;
	logic              ge;

	assign trial = {rem_q, work_q[DIV_NW-1]};
	assign ge = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? DIV_DW'(trial - {1'b0, dvs_q}) : DIV_DW'(trial);
			work_q <= {work_q[DIV_NW-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient = work_q;
endmodule

[sv/tkf_acos_rom.sv]
// Arccos lookup ROM, contents built at elaboration by integer CORDIC.
module tkf_acos_rom import tkf_pkg::*; #(
	parameter int ACOS_TABLE_DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic [$clog2(ACOS_TABLE_DEPTH+1)-1:0] addr,
	output logic [ACOS_W-1:0]                     data
);
	typedef logic [ACOS_W-1:0] rom_t [0:ACOS_TABLE_DEPTH];

	// arccos of c (Q30, 0..1) in Q16.16 degrees
	function automatic longint acos_first_quadrant(input longint unsigned c);
		longint unsigned v;
		longint unsigned r;
		longint unsigned b;
		longint x;
		longint y;
		longint z;
		longint xs;
		longint ys;
		v = (64'd1 << 60) - c * c;
		r = 0;
		b = 64'd1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		x = longint'(c);
		y = longint'(r);
		z = 0;
		for (int i = 0; i < 20; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_Q16[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_Q16[i];
			end
		end
		if (z < 0)
			z = 0;
		if (z > QUARTER_TURN_Q16)
			z = QUARTER_TURN_Q16;
		return z;
	endfunction

	function automatic rom_t build_rom();
		rom_t t;
		longint m;
		longint unsigned mag;
		longint a;
		for (int i = 0; i <= ACOS_TABLE_DEPTH; i++) begin
			m = 2 * i - ACOS_TABLE_DEPTH;
			mag = (m < 0) ? longint'(-m) : longint'(m);
			a = acos_first_quadrant((mag << 30) / ACOS_TABLE_DEPTH);
			t[i] = ACOS_W'((m < 0) ? (HALF_TURN_Q16 - a) : a);
		end
		return t;
	endfunction

	localparam rom_t ROM = build_rom();

	logic [ACOS_W-1:0] data_q;

	always_ff @(posedge clk) begin
		data_q <= ROM[addr];
	end

	assign data = data_q;
endmodule

[sv/tilt_kalman_fusion_unit.sv]
// Tilt Kalman fusion unit: sequencer, state registers and datapath around shared mul/div.
// The correction, with its two gain divisions on the shared divider, is skipped when the
// divisor is not positive. A new word is taken only when the sequencer is idle, so the
// unit cannot take a new word before it is through with the last; a stalled output word
// holds the sequencer in its last state.
// Reset: angle and bias clear, covariance goes to identity, registers to their defaults.
module tilt_kalman_fusion_unit import tkf_pkg::*; #(
	parameter int ACOS_TABLE_DEPTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [15:0]  gyro_sample,
	input  logic [11:0]         accel_sample,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [16:0]  fused_angle,
	output logic signed [20:0]  angle_rate,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [23:0]         cfg_data
);
	localparam int AW = $clog2(ACOS_TABLE_DEPTH + 1);
	localparam int PW = AW + 16;

	state_t state_q, state_d;

	// configuration
	logic signed [15:0] gyro_offset_q;
	logic [15:0]        gyro_scale_q;
	logic [19:0]        accel_level_mid_q;
	logic [23:0]        angle_process_noise_q;
	logic [23:0]        bias_process_noise_q;
	logic [23:0]        measure_noise_q;

	// filter state
	logic signed [31:0] angle_q, bias_q, p00_q, p01_q, p10_q, p11_q;

	// per-item working registers
	logic signed [15:0] gs_q;
	logic [11:0]        acc_q;
	logic signed [33:0] rate_q;
	logic [34:0]        npos_q;
	logic [35:0]        y_q;
	logic [28:0]        q0_q;
	logic [PW-1:0]      pos_q;
	logic [ACOS_W-1:0]  lo_q;
	logic signed [24:0] accang_q;
	logic signed [31:0] k0_q, k1_q;
	logic               out_valid_q;
	logic signed [16:0] fused_q;
	logic signed [20:0] rate_out_q;

	logic signed [MUL_AW-1:0] mul_a;
	logic signed [MUL_BW-1:0] mul_b;
	logic signed [MUL_PW-1:0] prod;

	logic              div_start;
	logic [DIV_NW-1:0] div_dvd;
	logic [DIV_DW-1:0] div_dvs;
	div_stat_t         div_stat;
	logic [DIV_NW-1:0] div_quo;

	logic [AW-1:0]     rom_addr;
	logic [ACOS_W-1:0] rom_data;

	logic [AW-1:0]      idx;
	logic               idx_last;
	logic signed [32:0] e_val;
	logic               e_pos;
	logic signed [22:0] x_val;
	logic signed [39:0] n_val;
	logic signed [39:0] n_clamp;
	logic signed [32:0] ang_r;
	logic signed [35:0] spd_r;
	logic               out_free;
	logic signed [31:0] accang_n;
	logic [9:0]         pos_rem;

	assign idx = pos_q[PW-1:16];
	assign idx_last = idx == AW'(ACOS_TABLE_DEPTH);
	assign e_val = $signed({9'b0, measure_noise_q}) + 33'(p00_q);
	assign e_pos = !e_val[32] && (e_val != 33'sd0);
	assign x_val = $signed({3'b000, acc_q, 8'h00}) + ACC_BIAS_Q8
		- $signed({3'b000, accel_level_mid_q});
	assign n_val = 40'(prod) - MV_OFFSET_Q20;
	assign n_clamp = (n_val > COS_DEN) ? COS_DEN : ((n_val < -COS_DEN) ? -COS_DEN : n_val);
	assign out_free = !out_valid_q || !out_stall;
	assign accang_n = rnd_acc($signed({8'b0, lo_q}), prod, 16, 1'b0);
	// remainder of the estimate is below three steps, so ten low bits hold it
	assign pos_rem = 10'(y_q - prod[35:0]);

	assign ang_r = (33'(angle_q) + 33'sd128) >>> 8;
	assign spd_r = (36'(rate_q) - 36'(bias_q) + 36'sd128) >>> 8;

	tkf_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	tkf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	tkf_acos_rom #(
		.ACOS_TABLE_DEPTH (ACOS_TABLE_DEPTH)
	) u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// sequencer and operand selection
	always_comb begin
		state_d = state_q;
		mul_a = '0;
		mul_b = '0;
		div_start = 1'b0;
		div_dvd = '0;
		div_dvs = '0;
		rom_addr = idx;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_M_RATE;
			end
			ST_M_RATE: begin
				mul_a = 36'($signed({gs_q[15], gs_q}) - $signed({gyro_offset_q[15], gyro_offset_q}));
				mul_b = $signed({17'b0, gyro_scale_q});
				state_d = ST_W_RATE;
			end
			ST_W_RATE: state_d = ST_M_X;
			ST_M_X: begin
				mul_a = 36'(x_val);
				mul_b = MV_NUM;
				state_d = ST_W_X;
			end
			ST_W_X: state_d = ST_M_POS;
			ST_M_POS: begin
				mul_a = $signed({1'b0, npos_q});
				mul_b = 33'(ACOS_TABLE_DEPTH);
				state_d = ST_W_POS;
			end
			ST_W_POS: state_d = ST_M_REC;
			ST_M_REC: begin
				mul_a = $signed({4'b0, y_q[35:4]});
				mul_b = $signed(POS_RECIP);
				state_d = ST_W_REC;
			end
			ST_W_REC: state_d = ST_M_BACK;
			ST_M_BACK: begin
				mul_a = $signed({7'b0, q0_q});
				mul_b = $signed({23'b0, POS_STEP});
				state_d = ST_W_BACK;
			end
			ST_W_BACK: state_d = ST_RD0;
			ST_RD0: begin
				rom_addr = idx;
				state_d = ST_RD1;
			end
			ST_RD1: begin
				rom_addr = idx_last ? idx : idx + AW'(1);
				state_d = ST_RD2;
			end
			ST_RD2: begin
				mul_a = 36'($signed({1'b0, rom_data}) - $signed({1'b0, lo_q}));
				mul_b = $signed({17'b0, pos_q[15:0]});
				state_d = ST_W_INT;
			end
			ST_W_INT: state_d = ST_M_ANG;
			ST_M_ANG: begin
				mul_a = 36'(rate_q) - 36'(bias_q);
				mul_b = $signed({8'b0, DT_Q32});
				state_d = ST_W_ANG;
			end
			ST_W_ANG: state_d = ST_M_P00;
			ST_M_P00: begin
				mul_a = $signed({12'b0, angle_process_noise_q}) - 36'(p01_q) - 36'(p10_q);
				mul_b = $signed({8'b0, DT_Q32});
				state_d = ST_W_P00;
			end
			ST_W_P00: state_d = ST_M_P01;
			ST_M_P01: begin
				mul_a = -36'(p11_q);
				mul_b = $signed({8'b0, DT_Q32});
				state_d = ST_W_P01;
			end
			ST_W_P01: state_d = ST_M_P11;
			ST_M_P11: begin
				mul_a = $signed({12'b0, bias_process_noise_q});
				mul_b = $signed({8'b0, DT_Q32});
				state_d = ST_W_P11;
			end
			ST_W_P11: state_d = ST_GAIN;
			ST_GAIN: begin
				if (e_pos) begin
					div_start = 1'b1;
					div_dvd = {mag32(p00_q), 24'b0};
					div_dvs = DIV_DW'(e_val);
					state_d = ST_D_K0;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_D_K0: begin
				if (div_stat.done) begin
					div_start = 1'b1;
					div_dvd = {mag32(p10_q), 24'b0};
					div_dvs = DIV_DW'(e_val);
					state_d = ST_D_K1;
				end
			end
			ST_D_K1: begin
				if (div_stat.done)
					state_d = ST_M_C11;
			end
			// covariance correction ordered so each term still sees the old entries
			ST_M_C11: begin
				mul_a = 36'(p01_q);
				mul_b = 33'(k1_q);
				state_d = ST_W_C11;
			end
			ST_W_C11: state_d = ST_M_C10;
			ST_M_C10: begin
				mul_a = 36'(p00_q);
				mul_b = 33'(k1_q);
				state_d = ST_W_C10;
			end
			ST_W_C10: state_d = ST_M_C01;
			ST_M_C01: begin
				mul_a = 36'(p01_q);
				mul_b = 33'(k0_q);
				state_d = ST_W_C01;
			end
			ST_W_C01: state_d = ST_M_C00;
			ST_M_C00: begin
				mul_a = 36'(p00_q);
				mul_b = 33'(k0_q);
				state_d = ST_W_C00;
			end
			ST_W_C00: state_d = ST_M_BIAS;
			// bias first: the innovation uses the predicted angle
			ST_M_BIAS: begin
				mul_a = 36'(accang_q) - 36'(angle_q);
				mul_b = 33'(k1_q);
				state_d = ST_W_BIAS;
			end
			ST_W_BIAS: state_d = ST_M_ANGC;
			ST_M_ANGC: begin
				mul_a = 36'(accang_q) - 36'(angle_q);
				mul_b = 33'(k0_q);
				state_d = ST_W_ANGC;
			end
			ST_W_ANGC: state_d = ST_FIN;
			ST_FIN: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// configuration, filter state and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_offset_q <= 16'sd35;
			gyro_scale_q <= 16'd4588;
			accel_level_mid_q <= 20'd310211;
			angle_process_noise_q <= 24'd1678;
			bias_process_noise_q <= 24'd5033;
			measure_noise_q <= 24'd1510;
			angle_q <= '0;
			bias_q <= '0;
			p00_q <= ONE_Q24;
			p01_q <= '0;
			p10_q <= '0;
			p11_q <= ONE_Q24;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_GYRO_OFFSET:   gyro_offset_q <= $signed(cfg_data[15:0]);
					CFG_GYRO_SCALE:    gyro_scale_q <= cfg_data[15:0];
					CFG_ACCEL_MID:     accel_level_mid_q <= cfg_data[19:0];
					CFG_ANGLE_NOISE:   angle_process_noise_q <= cfg_data;
					CFG_BIAS_NOISE:    bias_process_noise_q <= cfg_data;
					CFG_MEASURE_NOISE: measure_noise_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_W_ANG:  angle_q <= rnd_acc(angle_q, prod, 32, 1'b0);
				ST_W_P00:  p00_q <= rnd_acc(p00_q, prod, 32, 1'b0);
				ST_W_P01: begin
					p01_q <= rnd_acc(p01_q, prod, 32, 1'b0);
					p10_q <= rnd_acc(p10_q, prod, 32, 1'b0);
				end
				ST_W_P11:  p11_q <= rnd_acc(p11_q, prod, 32, 1'b0);
				ST_W_C11:  p11_q <= rnd_acc(p11_q, prod, 24, 1'b1);
				ST_W_C10:  p10_q <= rnd_acc(p10_q, prod, 24, 1'b1);
				ST_W_C01:  p01_q <= rnd_acc(p01_q, prod, 24, 1'b1);
				ST_W_C00:  p00_q <= rnd_acc(p00_q, prod, 24, 1'b1);
				ST_W_BIAS: bias_q <= rnd_acc(bias_q, prod, 24, 1'b0);
				ST_W_ANGC: angle_q <= rnd_acc(angle_q, prod, 24, 1'b0);
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				gs_q <= gyro_sample;
				acc_q <= accel_sample;
			end
			ST_W_RATE: rate_q <= 34'(prod);
			ST_W_X:    npos_q <= 35'(n_clamp + COS_DEN);
			ST_W_POS:  y_q <= prod[45:10];
			ST_W_REC:  q0_q <= prod[60:32];
			ST_W_BACK: begin
				pos_q <= PW'(q0_q + ((pos_rem >= POS_STEP2) ? 29'd2
					: ((pos_rem >= POS_STEP) ? 29'd1 : 29'd0)));
			end
			ST_RD1:    lo_q <= rom_data;
			ST_W_INT:  accang_q <= idx_last ? $signed({1'b0, lo_q}) : 25'(accang_n);
			ST_D_K0: begin
				if (div_stat.done)
					k0_q <= gain_sat(div_quo, p00_q[31]);
			end
			ST_D_K1: begin
				if (div_stat.done)
					k1_q <= gain_sat(div_quo, p10_q[31]);
			end
			ST_FIN: begin
				if (out_free) begin
					fused_q <= (ang_r > 33'(FUSED_LIM)) ? 17'(FUSED_LIM)
						: ((ang_r < -33'(FUSED_LIM)) ? -17'(FUSED_LIM) : 17'(ang_r));
					rate_out_q <= (spd_r > 36'sd1048575) ? 21'sd1048575
						: ((spd_r < -36'sd1048576) ? -21'sd1048576 : 21'(spd_r));
				end
			end
			default: ;
		endcase
	end

	assign in_stall = state_q != ST_IDLE;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign fused_angle = fused_q;
	assign angle_rate = rate_out_q;

	a_div_busy_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> (state_q == ST_D_K0 || state_q == ST_D_K1))
		else $error("divider busy outside a wait state");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_M_C11 |-> (k0_q <= 32'sd1073741824 && k0_q >= -32'sd1073741824 &&
			k1_q <= 32'sd1073741824 && k1_q >= -32'sd1073741824))
		else $error("gain beyond limit");

	a_rom_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD0 |-> idx <= AW'(ACOS_TABLE_DEPTH))
		else $error("table index beyond last entry");

	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == ST_M_RATE)
		else $error("accepted word did not start the sequence");

	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN && out_valid && out_stall |=> state_q == ST_FIN && out_valid)
		else $error("result dropped while output stalled");
endmodule
